[hw/rtl/iqm_pkg.sv]
// Shared constants and types for the interquartile mean filter.
package iqm_pkg;

    // Block size and the field widths of one beat.
    localparam int BLOCK_SAMPLES = 64;
    localparam int SAMPLE_W      = 12;
    localparam int SUM_W         = 17;

    // Sorted window bounds and the divisor, as truncated quotients.
    localparam int LO_IDX   = BLOCK_SAMPLES / 4;
    localparam int HI_IDX   = (BLOCK_SAMPLES * 3) / 4;
    localparam int HALF     = BLOCK_SAMPLES / 2;
    localparam int WIN_CNT  = HI_IDX - LO_IDX;

    // The block size is a power of two, so dividing by half of it is a right shift.
    localparam int HALF_SH  = $clog2(HALF);

    // Store index and fill count widths.
    localparam int IDX_W = $clog2(BLOCK_SAMPLES);
    localparam int CNT_W = $clog2(BLOCK_SAMPLES + 1);

    // Accumulator wide enough for the full window sum and for the output field.
    localparam int ACC_RAW_W = SAMPLE_W + $clog2(WIN_CNT);
    localparam int ACC_W     = (ACC_RAW_W > SUM_W) ? ACC_RAW_W : SUM_W;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SUM_W + SAMPLE_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - SUM_W - SAMPLE_W;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SHIFT     = 6'b000010,
        ST_PLACE     = 6'b000100,
        ST_SUM_START = 6'b001000,
        ST_SUM       = 6'b010000,
        ST_DONE      = 6'b100000
    } iqm_state_t;

endpackage

[hw/rtl/interquartile_mean_filter.sv]
// Interquartile mean filter: insertion sort into a block store, window sum and mean.
//
// Usage: each beat on the s_ channel carries one 12-bit ADC sample. Samples are
// inserted in ascending order into a 64-entry store as they arrive. After every
// 64th sample the block sums sorted entries 16 to 47 and divides the sum by 32,
// then puts one beat on the m_ channel holding the sum and the truncated mean.
// Intermediate samples produce no output beat.
// Flow control: s_tready is high only while the sequencer is idle. Inserting a
// sample writes it straight to the first entry when the store is empty; otherwise
// the sequencer reads the stored entries from the top down, moving each larger one
// up one place, and then writes the sample. The store takes one read and one write a cycle.
// The last sample of a block is followed by the window sum (one store read
// per entry) and the load of the output register; the mean is the sum shifted
// right, as the divisor is a power of two.
// The output register holds a result until it is taken; the next block may be
// collected meanwhile, and only the following result waits for the register.
// Reset (aresetn low, synchronous) empties the block and drops any pending
// output beat; the store contents are not cleared, as no entry is read before
// it is written.
module interquartile_mean_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [iqm_pkg::S_TDATA_W-1:0] s_tdata,   // [11:0] sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [iqm_pkg::M_TDATA_W-1:0] m_tdata    // [16:0] middle_sum, [28:17] mean_value
);
    import iqm_pkg::*;

    // Sorted sample store.
    logic [SAMPLE_W-1:0] store_mem [BLOCK_SAMPLES];

    iqm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [SAMPLE_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]    m_sum_reg, m_sum_next;
    logic [SAMPLE_W-1:0] m_mean_reg, m_mean_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [ACC_W-1:0]    mean_full;
    logic [CNT_W-1:0]    fill_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_mean_reg, m_sum_reg};

    // Mean of the window: the sum divided by half the block size.
    assign mean_full = acc_reg >> HALF_SH;
    assign fill_inc  = fill_reg + CNT_W'(1);

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_sum_next   = m_sum_reg;
        m_mean_next  = m_mean_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = val_reg;
        rd_en        = 1'b0;
        rd_addr      = pos_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    val_next = s_tdata[SAMPLE_W-1:0];
                    pos_next = fill_reg[IDX_W-1:0];
                    if (fill_reg == '0) begin
                        // Empty block: the sample goes straight to the first entry.
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_data   = s_tdata[SAMPLE_W-1:0];
                        fill_next = fill_inc;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = fill_reg[IDX_W-1:0] - IDX_W'(1);
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT: begin
                wr_en = 1'b1;
                if (rd_data_reg > val_reg) begin
                    // Move the larger entry up one place and look further down.
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg - IDX_W'(1);
                    if (pos_reg == IDX_W'(1)) begin
                        state_next = ST_PLACE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_reg - IDX_W'(2);
                    end
                end else begin
                    fill_next  = fill_inc;
                    state_next = (fill_inc == CNT_W'(BLOCK_SAMPLES)) ? ST_SUM_START
                                                                      : ST_IDLE;
                end
            end

            ST_PLACE: begin
                wr_en      = 1'b1;
                fill_next  = fill_inc;
                state_next = (fill_inc == CNT_W'(BLOCK_SAMPLES)) ? ST_SUM_START : ST_IDLE;
            end

            ST_SUM_START: begin
                acc_next   = '0;
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(LO_IDX);
                cnt_next   = CNT_W'(LO_IDX + 1);
                state_next = ST_SUM;
            end

            ST_SUM: begin
                // Add the entry read last cycle and, until the window end, fetch the next one.
                acc_next = acc_reg + ACC_W'(rd_data_reg);
                if (cnt_reg == CNT_W'(HI_IDX)) begin
                    state_next = ST_DONE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = cnt_reg[IDX_W-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_DONE: begin
                // Load the output register once the previous beat has gone.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = acc_reg[SUM_W-1:0];
                    m_mean_next  = mean_full[SAMPLE_W-1:0];
                    fill_next    = '0;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        m_sum_reg  <= m_sum_next;
        m_mean_reg <= m_mean_next;
    end

    // Store write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

endmodule

[tb/iqm_checker.sv]
// Checker for the interquartile mean filter: watches both channels, predicts and compares.
module iqm_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [iqm_pkg::S_TDATA_W-1:0] s_tdata,    // [11:0] sample
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [iqm_pkg::M_TDATA_W-1:0] m_tdata,    // [16:0] middle_sum, [28:17] mean_value
    output int                            fail_count,
    output int                            pending
);
    import iqm_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0]    middle_sum;
        logic [SAMPLE_W-1:0] mean_value;
    } block_result_t;

    // Own copy of the sorted block and how many samples it holds.
    logic [SAMPLE_W-1:0] sorted_block [BLOCK_SAMPLES];
    int                  block_fill = 0;

    // Results predicted but not yet seen on the output channel.
    block_result_t       expected_results [$];
    block_result_t       want;
    logic [SUM_W-1:0]    got_sum;
    logic [SAMPLE_W-1:0] got_mean;

    int mismatches = 0;
    int open_count = 0;

    assign fail_count = mismatches;
    assign pending    = open_count;

    // Insert one sample in ascending order, after any equal entries; a full block
    // yields the window sum over the middle half and its truncated mean.
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] v);
        int            pos;
        int            i;
        logic [31:0]   window_sum;
        logic [31:0]   quotient;
        block_result_t res;
        begin
            pos = block_fill;
            while (pos > 0 && sorted_block[pos-1] > v) begin
                sorted_block[pos] = sorted_block[pos-1];
                pos--;
            end
            sorted_block[pos] = v;
            block_fill++;
            if (block_fill == BLOCK_SAMPLES) begin
                window_sum = '0;
                for (i = LO_IDX; i < HI_IDX; i++) begin
                    window_sum += 32'(sorted_block[i]);
                end
                quotient       = window_sum / HALF;
                res.middle_sum = window_sum[SUM_W-1:0];
                res.mean_value = quotient[SAMPLE_W-1:0];
                expected_results.push_back(res);
                block_fill = 0;
            end
        end
    endtask

    // Check the output beat first, then take in the input beat of the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            block_fill = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_sum  = m_tdata[SUM_W-1:0];
                got_mean = m_tdata[SUM_W +: SAMPLE_W];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, got sum %0d mean %0d",
                             $time, got_sum, got_mean);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got_sum !== want.middle_sum) begin
                        $display("%0t: middle_sum mismatch: expected %0d, got %0d",
                                 $time, want.middle_sum, got_sum);
                        mismatches++;
                    end
                    if (got_mean !== want.mean_value) begin
                        $display("%0t: mean_value mismatch: expected %0d, got %0d",
                                 $time, want.mean_value, got_mean);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                absorb_sample(s_tdata[SAMPLE_W-1:0]);
            end
        end
        open_count = expected_results.size();
    end

endmodule

[tb/testbench.sv]
// Top-level testbench for the interquartile mean filter: clock, reset, stimulus and verdict.
module testbench;
    import iqm_pkg::*;

    // Shapes of a block of samples.
    typedef enum int {
        PAT_ALL_MAX,
        PAT_ALL_ZERO,
        PAT_DESCEND,
        PAT_ASCEND,
        PAT_CONST,
        PAT_FEW,
        PAT_EXTREMES,
        PAT_RANDOM
    } block_shape_t;

    localparam int NUM_BLOCKS      = 27;
    localparam int IDLE_PCT        = 31;
    localparam int NUM_CORNERS     = 22;
    localparam int TX_QUIET_FIRST  = 9;
    localparam int TX_QUIET_LAST   = 12;
    localparam int RX_QUIET_FIRST  = 14;
    localparam int RX_QUIET_LAST   = 19;
    localparam int HOLD_AFTER      = 2;
    localparam int HOLD_CYCLES     = 12000;
    localparam int PAUSE_A         = 5;
    localparam int PAUSE_B         = 21;
    localparam int DRAIN_CYCLES    = 150;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int send_idle_pct = IDLE_PCT;
    int results_taken = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    logic [SAMPLE_W-1:0] block_vals  [BLOCK_SAMPLES];
    logic [SAMPLE_W-1:0] corner_vals [NUM_CORNERS];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    interquartile_mean_filter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    iqm_checker scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one sample beat, at times after a random idle gap, and wait until it is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        begin
            if ($urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, v};
            do @(posedge aclk); while (!s_tready);
        end
    endtask

    // Fill one block of samples with the given shape and random content.
    task automatic fill_block(input block_shape_t shape);
        int                  i;
        int                  level;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] few [3];
        begin
            base   = SAMPLE_W'($urandom_range(0, 4095));
            few[0] = SAMPLE_W'($urandom_range(0, 4095));
            few[1] = SAMPLE_W'($urandom_range(0, 4095));
            few[2] = few[0];
            level  = (shape == PAT_DESCEND) ? 4095 - $urandom_range(0, 200)
                                            : $urandom_range(0, 200);
            for (i = 0; i < BLOCK_SAMPLES; i++) begin
                case (shape)
                    PAT_ALL_MAX:  block_vals[i] = '1;
                    PAT_ALL_ZERO: block_vals[i] = '0;
                    PAT_DESCEND: begin
                        level = level - $urandom_range(0, 63);
                        if (level < 0) level = 0;
                        block_vals[i] = SAMPLE_W'(level);
                    end
                    PAT_ASCEND: begin
                        level = level + $urandom_range(0, 63);
                        if (level > 4095) level = 4095;
                        block_vals[i] = SAMPLE_W'(level);
                    end
                    PAT_CONST:    block_vals[i] = base;
                    PAT_FEW:      block_vals[i] = few[$urandom_range(0, 2)];
                    PAT_EXTREMES: block_vals[i] = $urandom_range(0, 1) ? '1 : '0;
                    default:      block_vals[i] = SAMPLE_W'($urandom_range(0, 4095));
                endcase
            end
        end
    endtask

    // Receiver: random back-pressure, one long hold-off and a stretch without stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) results_taken <= results_taken + 1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && results_taken == HOLD_AFTER) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (results_taken >= RX_QUIET_FIRST && results_taken <= RX_QUIET_LAST) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int           b;
        int           i;
        block_shape_t shape;

        // Field extremes, single set bits, alternating patterns and equal samples.
        corner_vals = '{12'd0, 12'd4095, 12'd0, 12'd4095,
                        12'd1, 12'd2, 12'd4, 12'd8, 12'd16, 12'd32,
                        12'd64, 12'd128, 12'd256, 12'd512, 12'd1024, 12'd2048,
                        12'd4094, 12'd2730, 12'd1365, 12'd7, 12'd7, 12'd7};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (b = 0; b < NUM_BLOCKS; b++) begin
            // Every shape once in turn, then shapes at random.
            if (b == 0) begin
                shape = PAT_RANDOM;
            end else if (b <= int'(PAT_EXTREMES) + 1) begin
                shape = block_shape_t'(b - 1);
            end else begin
                shape = block_shape_t'($urandom_range(0, int'(PAT_RANDOM)));
            end
            fill_block(shape);
            if (b == 0) begin
                for (i = 0; i < NUM_CORNERS; i++) block_vals[i] = corner_vals[i];
            end

            send_idle_pct = (b >= TX_QUIET_FIRST && b <= TX_QUIET_LAST) ? 0 : IDLE_PCT;
            for (i = 0; i < BLOCK_SAMPLES; i++) begin
                send_sample(block_vals[i]);
            end

            // Now and then let the block drain completely before the next one.
            if (b == PAUSE_A || b == PAUSE_B) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait (pending == 0);
                @(posedge aclk);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #10000000;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/iqm_pkg.sv
hw/rtl/interquartile_mean_filter.sv
tb/iqm_checker.sv
tb/testbench.sv
